// ----- sv/hrsp_pkg.sv -----
package hrsp_pkg;

    localparam int ADDR_IN_W = 12;
    localparam int PAYLOAD_W = 64;

    localparam logic [2:0] REQ_TICK  = 3'd0;
    localparam logic [2:0] REQ_WRITE = 3'd1;
    localparam logic [2:0] REQ_PAUSE = 3'd2;
    localparam logic [2:0] REQ_STEP  = 3'd3;
    localparam logic [2:0] REQ_ZERO  = 3'd4;

    localparam logic [2:0] KIND_NOP      = 3'd0;
    localparam logic [2:0] KIND_DELAY    = 3'd1;
    localparam logic [2:0] KIND_KEYBOARD = 3'd2;
    localparam logic [2:0] KIND_MOUSE    = 3'd3;
    localparam logic [2:0] KIND_END      = 3'd4;

    localparam logic [3:0] LEN_KEYBOARD = 4'd9;
    localparam logic [3:0] LEN_MOUSE    = 4'd5;

    typedef struct packed {
        logic [2:0]           kind;
        logic [PAYLOAD_W-1:0] payload;
    } entry_t;

    typedef struct packed {
        logic take;
        logic clear_wr;
        logic red_step;
        logic mem_wr;
        logic exec;
    } ctl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic red_skip;
        logic red_last;
        logic exec_stall;
    } ctl_status_t;

    // number of conditional subtract steps that fold a 12 bit slot into the depth
    function automatic int red_steps(input int depth);
        int count;
        count = 0;
        for (int k = 0; k < 9; k++)
        begin
            if ((depth << k) <= 4095)
            begin
                count = count + 1;
            end
        end
        return count;
    endfunction

endpackage

// ----- sv/hrsp_req_if.sv -----
interface hrsp_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [11:0] entry_address;
    logic [2:0]  entry_kind;
    logic [63:0] entry_payload;

    modport source (
        output valid,
        output req_type,
        output entry_address,
        output entry_kind,
        output entry_payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  req_type,
        input  entry_address,
        input  entry_kind,
        input  entry_payload,
        output ready
    );
endinterface

// ----- sv/hrsp_rpt_if.sv -----
interface hrsp_rpt_if;
    logic        valid;
    logic        ready;
    logic        report_kind;
    logic [3:0]  report_length;
    logic [63:0] report_bytes;
    logic [11:0] sent_position;
    logic        led_level;
    logic        now_paused;

    modport source (
        output valid,
        output report_kind,
        output report_length,
        output report_bytes,
        output sent_position,
        output led_level,
        output now_paused,
        input  ready
    );

    modport sink (
        input  valid,
        input  report_kind,
        input  report_length,
        input  report_bytes,
        input  sent_position,
        input  led_level,
        input  now_paused,
        output ready
    );
endinterface

// ----- sv/hrsp_controller.sv -----
module hrsp_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [2:0]          in_req_type,
    output logic                in_ready,
    output hrsp_pkg::ctl_cmd_t  cmd,
    input  hrsp_pkg::ctl_status_t status
);
    import hrsp_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_REDUCE,
        S_WRITE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (in_req_type == REQ_TICK)
                    begin
                        state_next = S_EXEC;
                    end
                    else if (in_req_type == REQ_WRITE)
                    begin
                        state_next = status.red_skip ? S_WRITE : S_REDUCE;
                    end
                end
            end
            S_REDUCE:
            begin
                cmd.red_step = 1'b1;
                if (status.red_last)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.mem_wr = 1'b1;
                state_next = S_IDLE;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (!status.exec_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/hrsp_datapath.sv -----
module hrsp_datapath #(
    parameter int SCRIPT_DEPTH = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hrsp_pkg::ctl_cmd_t    cmd,
    output hrsp_pkg::ctl_status_t status,
    input  logic [2:0]            req_type,
    input  logic [11:0]           entry_address,
    input  logic [2:0]            entry_kind,
    input  logic [63:0]           entry_payload,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  report_kind,
    output logic [3:0]            report_length,
    output logic [63:0]           report_bytes,
    output logic [11:0]           sent_position,
    output logic                  led_level,
    output logic                  now_paused
);
    import hrsp_pkg::*;

    localparam int AW        = $clog2(SCRIPT_DEPTH);
    localparam int RED_STEPS = red_steps(SCRIPT_DEPTH);
    localparam int RED_FIRST = (RED_STEPS > 0) ? RED_STEPS - 1 : 0;
    localparam int LAST_SLOT = SCRIPT_DEPTH - 1;

    entry_t script_mem [SCRIPT_DEPTH];

    logic [AW-1:0] pos_reg;
    logic          pause_reg;
    logic          step_reg;
    logic          in_delay_reg;
    logic [8:0]    delay_left_reg;
    logic          led_reg;
    logic [AW-1:0] clear_addr_reg;
    logic          out_valid_reg;

    logic [11:0]   wr_addr_reg;
    entry_t        wr_entry_reg;
    logic [3:0]    red_k_reg;
    entry_t        rdata_reg;

    logic          out_kind_reg;
    logic [3:0]    out_len_reg;
    logic [63:0]   out_bytes_reg;
    logic [11:0]   out_pos_reg;
    logic          out_led_reg;
    logic          out_paused_reg;

    logic [31:0]   red_bound;
    logic          red_ge;
    logic [31:0]   wr_addr_wide;
    logic [AW-1:0] wr_slot;
    logic [31:0]   pos_wide;
    logic [AW-1:0] pos_inc;
    logic          run;
    logic          is_report;
    logic          exec_go;
    logic          report_go;
    logic          paused_after;

    assign red_bound    = 32'(SCRIPT_DEPTH) << red_k_reg;
    assign red_ge       = 32'(wr_addr_reg) >= red_bound;
    assign wr_addr_wide = 32'(wr_addr_reg);
    assign wr_slot      = wr_addr_wide[AW-1:0];
    assign pos_wide     = 32'(pos_reg);
    assign pos_inc      = (pos_reg == AW'(LAST_SLOT)) ? '0 : pos_reg + 1'b1;

    assign run          = !pause_reg || step_reg;
    assign is_report    = (rdata_reg.kind == KIND_KEYBOARD) || (rdata_reg.kind == KIND_MOUSE);
    assign status.exec_stall = cmd.exec && run && is_report && out_valid_reg && !out_ready;
    assign exec_go      = cmd.exec && !status.exec_stall && run;
    assign report_go    = exec_go && is_report;
    assign paused_after = step_reg ? 1'b1 : pause_reg;

    assign status.clear_last = (clear_addr_reg == AW'(LAST_SLOT));
    assign status.red_skip   = (RED_STEPS == 0);
    assign status.red_last   = (red_k_reg == '0);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            pause_reg      <= 1'b1;
            step_reg       <= 1'b0;
            in_delay_reg   <= 1'b0;
            delay_left_reg <= '0;
            led_reg        <= 1'b1;
            clear_addr_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clear_wr)
            begin
                clear_addr_reg <= clear_addr_reg + 1'b1;
            end

            if (cmd.take)
            begin
                case (req_type)
                    REQ_PAUSE: pause_reg <= !pause_reg;
                    REQ_STEP:  step_reg  <= 1'b1;
                    REQ_ZERO:  pos_reg   <= '0;
                    default:   ;
                endcase
            end

            if (exec_go)
            begin
                case (rdata_reg.kind)
                    KIND_NOP:
                    begin
                    end
                    KIND_DELAY:
                    begin
                        if (!in_delay_reg)
                        begin
                            delay_left_reg <= {1'b0, rdata_reg.payload[7:0]};
                            in_delay_reg   <= 1'b1;
                        end
                        else if (delay_left_reg <= 9'd1)
                        begin
                            delay_left_reg <= '0;
                            in_delay_reg   <= 1'b0;
                            pos_reg        <= pos_inc;
                        end
                        else
                        begin
                            delay_left_reg <= delay_left_reg - 1'b1;
                        end
                    end
                    KIND_KEYBOARD, KIND_MOUSE:
                    begin
                        led_reg   <= !led_reg;
                        step_reg  <= 1'b0;
                        pause_reg <= paused_after;
                        pos_reg   <= pos_inc;
                    end
                    default:
                    begin
                        pos_reg <= '0;
                    end
                endcase
            end

            if (report_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // script store
    always_ff @(posedge clk)
    begin
        if (cmd.clear_wr)
        begin
            script_mem[clear_addr_reg] <= '{kind: KIND_END, payload: '0};
        end
        else if (cmd.mem_wr)
        begin
            script_mem[wr_slot] <= wr_entry_reg;
        end
        rdata_reg <= script_mem[pos_reg];
    end

    // request capture, slot folding and report register
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            wr_addr_reg          <= entry_address;
            wr_entry_reg.kind    <= entry_kind;
            wr_entry_reg.payload <= entry_payload;
            red_k_reg            <= 4'(RED_FIRST);
        end
        else if (cmd.red_step)
        begin
            if (red_ge)
            begin
                wr_addr_reg <= wr_addr_reg - red_bound[11:0];
            end
            if (red_k_reg != '0)
            begin
                red_k_reg <= red_k_reg - 1'b1;
            end
        end

        if (report_go)
        begin
            out_kind_reg   <= (rdata_reg.kind == KIND_MOUSE);
            out_len_reg    <= (rdata_reg.kind == KIND_MOUSE) ? LEN_MOUSE : LEN_KEYBOARD;
            out_bytes_reg  <= rdata_reg.payload;
            out_pos_reg    <= pos_wide[11:0];
            out_led_reg    <= !led_reg;
            out_paused_reg <= paused_after;
        end
    end

    assign out_valid     = out_valid_reg;
    assign report_kind   = out_kind_reg;
    assign report_length = out_len_reg;
    assign report_bytes  = out_bytes_reg;
    assign sent_position = out_pos_reg;
    assign led_level     = out_led_reg;
    assign now_paused    = out_paused_reg;

endmodule

// ----- sv/hid_report_script_player.sv -----
// tick request: accepted, then executed on the registered store read in the exec state;
//   the exec state stalls only while a finished report still waits in the output register
// write request: accepted, folded by slot folding steps (none at depth 4096), then written
// pause, step and zero requests: handled on acceptance; at most one report per tick request
// reset: asynchronous, active low; then a clearing pass over every slot of the store
//   writes end entries into it while no request is accepted
module hid_report_script_player #(
    parameter int SCRIPT_DEPTH = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    hrsp_req_if.sink          req,
    hrsp_rpt_if.source        rpt
);
    import hrsp_pkg::*;

    ctl_cmd_t    cmd;
    ctl_status_t status;
    logic        in_ready;

    hrsp_controller u_controller (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (req.valid),
        .in_req_type (req.req_type),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .status      (status)
    );

    hrsp_datapath #(
        .SCRIPT_DEPTH (SCRIPT_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .req_type      (req.req_type),
        .entry_address (req.entry_address),
        .entry_kind    (req.entry_kind),
        .entry_payload (req.entry_payload),
        .out_valid     (rpt.valid),
        .out_ready     (rpt.ready),
        .report_kind   (rpt.report_kind),
        .report_length (rpt.report_length),
        .report_bytes  (rpt.report_bytes),
        .sent_position (rpt.sent_position),
        .led_level     (rpt.led_level),
        .now_paused    (rpt.now_paused)
    );

    assign req.ready = in_ready;

`ifndef SYNTHESIS
    a_report_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rpt.valid) |-> $past(cmd.exec))
        else $error("report appeared without a tick being executed");

    a_no_request_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_wr |-> !req.ready)
        else $error("request taken during store clearing");

    a_exec_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && !status.exec_stall) |=> !cmd.exec)
        else $error("tick execution repeated");

    a_stall_needs_full_output: assert property (@(posedge clk) disable iff (!rst_n)
        status.exec_stall |-> (rpt.valid && !rpt.ready))
        else $error("tick stalled with output free");
`endif

endmodule

// ----- test/hid_report_script_player_test.sv -----
module hid_report_script_player_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hrsp_pkg::*;

    localparam int STORE_DEPTH = 4096;
    localparam int RANDOM_REQUESTS = 1500;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 20;
    localparam int DIRECTED_ROWS = 26;

    localparam logic [2:0] KIND_UNKNOWN_TOP = 3'd7;
    localparam logic [2:0] REQ_UNUSED_LOW = 3'd5;
    localparam logic [2:0] REQ_UNUSED_TOP = 3'd7;

    typedef struct packed {
        logic                 kind;
        logic [3:0]           length;
        logic [PAYLOAD_W-1:0] bytes;
        logic [11:0]          position;
        logic                 led;
        logic                 paused;
    } report_t;

    typedef struct packed {
        logic [2:0]           req_type;
        logic [ADDR_IN_W-1:0] address;
        logic [2:0]           kind;
        logic [PAYLOAD_W-1:0] payload;
        logic                 fixed;
        logic                 fixed_sends;
        report_t              fixed_report;
    } request_t;

    localparam report_t NO_REPORT = '0;

    localparam request_t DIRECTED_TABLE [DIRECTED_ROWS] = '{
        // paused after reset
        '{REQ_TICK, 12'd0, KIND_NOP, 64'd0, 1'b1, 1'b0, NO_REPORT},
        '{REQ_STEP, 12'd0, KIND_NOP, 64'd0, 1'b0, 1'b0, NO_REPORT},
        // slot zero still holds an end entry
        '{REQ_TICK, 12'd0, KIND_NOP, 64'd0, 1'b0, 1'b0, NO_REPORT},
        '{REQ_WRITE, 12'd0, KIND_KEYBOARD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, NO_REPORT},
        '{REQ_WRITE, 12'd1, KIND_MOUSE, 64'd0, 1'b0, 1'b0, NO_REPORT},
        // zero delay count
        '{REQ_WRITE, 12'd2, KIND_DELAY, 64'hFFFF_FFFF_FFFF_FF00, 1'b0, 1'b0, NO_REPORT},
        '{REQ_WRITE, 12'd3, KIND_UNKNOWN_TOP, 64'd0, 1'b0, 1'b0, NO_REPORT},
        '{REQ_WRITE, 12'd4095, KIND_MOUSE, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, NO_REPORT},
        // single step sends and stays paused
        '{REQ_TICK, 12'd0, KIND_NOP, 64'd0, 1'b1, 1'b1,
          '{1'b0, LEN_KEYBOARD, 64'hFFFF_FFFF_FFFF_FFFF, 12'd0, 1'b0, 1'b1}},
        '{REQ_PAUSE, 12'd0, KIND_NOP, 64'd0, 1'b0, 1'b0, NO_REPORT},
        '{REQ_TICK, 12'd0, KIND_NOP, 64'd0, 1'b1, 1'b1,
          '{1'b1, LEN_MOUSE, 64'd0, 12'd1, 1'b1, 1'b0}},
        '{REQ_TICK, 12'd0, KIND_NOP, 64'd0, 1'b0, 1'b0, NO_REPORT},
        '{REQ_TICK, 12'd0, KIND_NOP, 64'd0, 1'b0, 1'b0, NO_REPORT},
        // unknown kind goes back to slot zero
        '{REQ_TICK, 12'd0, KIND_NOP, 64'd0, 1'b0, 1'b0, NO_REPORT},
        '{REQ_WRITE, 12'd0, KIND_NOP, 64'd0, 1'b0, 1'b0, NO_REPORT},
        '{REQ_TICK, 12'd0, KIND_NOP, 64'd0, 1'b0, 1'b0, NO_REPORT},
        '{REQ_ZERO, 12'd0, KIND_NOP, 64'd0, 1'b0, 1'b0, NO_REPORT},
        '{REQ_WRITE, 12'd0, KIND_DELAY, 64'd5, 1'b0, 1'b0, NO_REPORT},
        '{REQ_TICK, 12'd0, KIND_NOP, 64'd0, 1'b0, 1'b0, NO_REPORT},
        // delay flag survives a zero and a rewrite
        '{REQ_ZERO, 12'd0, KIND_NOP, 64'd0, 1'b0, 1'b0, NO_REPORT},
        '{REQ_WRITE, 12'd0, KIND_DELAY, 64'h80, 1'b0, 1'b0, NO_REPORT},
        '{REQ_TICK, 12'd0, KIND_NOP, 64'd0, 1'b0, 1'b0, NO_REPORT},
        '{REQ_UNUSED_LOW, 12'd0, KIND_NOP, 64'd0, 1'b1, 1'b0, NO_REPORT},
        '{REQ_UNUSED_TOP, 12'd4095, KIND_UNKNOWN_TOP, 64'hFFFF_FFFF_FFFF_FFFF,
          1'b1, 1'b0, NO_REPORT},
        '{REQ_WRITE, 12'd0, KIND_MOUSE, 64'h8000_0000_0000_0001, 1'b0, 1'b0, NO_REPORT},
        '{REQ_TICK, 12'd0, KIND_NOP, 64'd0, 1'b1, 1'b1,
          '{1'b1, LEN_MOUSE, 64'h8000_0000_0000_0001, 12'd0, 1'b0, 1'b0}}
    };

    logic clk;
    logic rst_n;

    hrsp_req_if req_ch();
    hrsp_rpt_if rpt_ch();

    hid_report_script_player dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rpt   (rpt_ch)
    );

    request_t    stimulus[$];
    report_t     expected_reports[$];
    int          random_requests = 0;
    int          requests_taken = 0;
    int          reports_checked = 0;
    int          mouse_reports = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;

    // player state as seen by the scoreboard
    entry_t      script_copy [STORE_DEPTH];
    logic [11:0] play_slot;
    logic        hold;
    logic        step_armed;
    logic        delay_running;
    logic [8:0]  delay_remaining;
    logic        led_now;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void queue_request(input logic [2:0] rt, input logic [11:0] addr,
                                          input logic [2:0] kd, input logic [63:0] pl);
        stimulus.push_back('{rt, addr, kd, pl, 1'b0, 1'b0, NO_REPORT});
        if (rt <= REQ_ZERO)
        begin
            random_requests++;
        end
    endfunction

    function automatic logic play_request(input request_t rq, output report_t sent);
        entry_t e;
        sent = NO_REPORT;
        case (rq.req_type)
            REQ_WRITE:
            begin
                script_copy[rq.address] = {rq.kind, rq.payload};
            end
            REQ_PAUSE:
            begin
                hold = ~hold;
            end
            REQ_STEP:
            begin
                step_armed = 1'b1;
            end
            REQ_ZERO:
            begin
                play_slot = '0;
            end
            REQ_TICK:
            begin
                if (hold && !step_armed)
                begin
                    return 1'b0;
                end
                e = script_copy[play_slot];
                if (e.kind == KIND_NOP)
                begin
                    return 1'b0;
                end
                if (e.kind == KIND_DELAY)
                begin
                    if (!delay_running)
                    begin
                        delay_remaining = {1'b0, e.payload[7:0]};
                        delay_running = 1'b1;
                    end
                    else if (delay_remaining <= 9'd1)
                    begin
                        delay_remaining = '0;
                        delay_running = 1'b0;
                        play_slot = play_slot + 12'd1;
                    end
                    else
                    begin
                        delay_remaining = delay_remaining - 9'd1;
                    end
                    return 1'b0;
                end
                if (e.kind != KIND_KEYBOARD && e.kind != KIND_MOUSE)
                begin
                    play_slot = '0;
                    return 1'b0;
                end
                led_now = ~led_now;
                if (step_armed)
                begin
                    step_armed = 1'b0;
                    hold = 1'b1;
                end
                sent.kind = (e.kind == KIND_MOUSE);
                sent.length = (e.kind == KIND_MOUSE) ? LEN_MOUSE : LEN_KEYBOARD;
                sent.bytes = e.payload;
                sent.position = play_slot;
                sent.led = led_now;
                sent.paused = hold;
                play_slot = play_slot + 12'd1;
                return 1'b1;
            end
            default:
            begin
            end
        endcase
        return 1'b0;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : scoreboard
        report_t  got;
        report_t  want;
        report_t  predicted;
        request_t taken;
        logic     sends;
        if (rpt_ch.valid && rpt_ch.ready)
        begin
            got = {rpt_ch.report_kind, rpt_ch.report_length, rpt_ch.report_bytes,
                   rpt_ch.sent_position, rpt_ch.led_level, rpt_ch.now_paused};
            if (expected_reports.size() == 0)
            begin
                $display("%0t: unexpected report, expected none, actual %h", $time, got);
                mismatch_count++;
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("report_kind", 64'(want.kind), 64'(got.kind));
                check_field("report_length", 64'(want.length), 64'(got.length));
                check_field("report_bytes", want.bytes, got.bytes);
                check_field("sent_position", 64'(want.position), 64'(got.position));
                check_field("led_level", 64'(want.led), 64'(got.led));
                check_field("now_paused", 64'(want.paused), 64'(got.paused));
                reports_checked++;
                if (got.kind)
                begin
                    mouse_reports++;
                end
            end
        end
        if (req_ch.valid && req_ch.ready)
        begin
            taken = stimulus[requests_taken];
            taken.req_type = req_ch.req_type;
            taken.address = req_ch.entry_address;
            taken.kind = req_ch.entry_kind;
            taken.payload = req_ch.entry_payload;
            sends = play_request(taken, predicted);
            if (taken.fixed)
            begin
                if (taken.fixed_sends)
                begin
                    expected_reports.push_back(taken.fixed_report);
                end
            end
            else if (sends)
            begin
                expected_reports.push_back(predicted);
            end
            requests_taken++;
        end
    end

    always @(posedge clk)
    begin
        rpt_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("run stopped after %0d cycles with %0d reports outstanding",
                     cycle_count, expected_reports.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin : stimulus_and_end
        int          script_len;
        int          ticks;
        int          pick;
        int          main_requests;
        logic [2:0]  kind;
        logic [63:0] payload;

        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.req_type <= REQ_TICK;
        req_ch.entry_address <= '0;
        req_ch.entry_kind <= KIND_NOP;
        req_ch.entry_payload <= '0;

        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            script_copy[i] = {KIND_END, 64'd0};
        end
        play_slot = '0;
        hold = 1'b1;
        step_armed = 1'b0;
        delay_running = 1'b0;
        delay_remaining = '0;
        led_now = 1'b1;

        foreach (DIRECTED_TABLE[r])
        begin
            stimulus.push_back(DIRECTED_TABLE[r]);
        end

        // mostly short scripts from slot zero, played with random ticks
        while (random_requests < RANDOM_REQUESTS)
        begin
            if ($urandom_range(0, 99) < 70)
            begin
                script_len = $urandom_range(1, 8);
                for (int s = 0; s < script_len; s++)
                begin
                    pick = $urandom_range(0, 99);
                    payload = {$urandom, $urandom};
                    if (pick < 35)
                    begin
                        kind = KIND_KEYBOARD;
                    end
                    else if (pick < 65)
                    begin
                        kind = KIND_MOUSE;
                    end
                    else if (pick < 85)
                    begin
                        kind = KIND_DELAY;
                        pick = $urandom_range(0, 99);
                        if (pick < 85)
                        begin
                            payload[7:0] = 8'($urandom_range(0, 3));
                        end
                        else if (pick < 97)
                        begin
                            payload[7:0] = 8'($urandom_range(4, 20));
                        end
                        else
                        begin
                            payload[7:0] = 8'($urandom_range(0, 255));
                        end
                    end
                    else if (pick < 88)
                    begin
                        kind = KIND_NOP;
                    end
                    else
                    begin
                        kind = 3'($urandom_range(KIND_END, KIND_UNKNOWN_TOP));
                    end
                    queue_request(REQ_WRITE, 12'(s), kind, payload);
                end
                if ($urandom_range(0, 99) < 85)
                begin
                    queue_request(REQ_WRITE, 12'(script_len),
                                  3'($urandom_range(KIND_END, KIND_UNKNOWN_TOP)),
                                  {$urandom, $urandom});
                end
                queue_request(REQ_ZERO, 12'($urandom), 3'($urandom), {$urandom, $urandom});
                pick = $urandom_range(0, 2);
                if (pick == 0)
                begin
                    queue_request(REQ_PAUSE, 12'($urandom), 3'($urandom), {$urandom, $urandom});
                end
                else if (pick == 1)
                begin
                    queue_request(REQ_STEP, 12'($urandom), 3'($urandom), {$urandom, $urandom});
                end
                ticks = $urandom_range(1, 40);
                for (int t = 0; t < ticks; t++)
                begin
                    if ($urandom_range(0, 99) < 5)
                    begin
                        queue_request(3'($urandom_range(REQ_PAUSE, REQ_STEP)), 12'($urandom),
                                      3'($urandom), {$urandom, $urandom});
                    end
                    queue_request(REQ_TICK, 12'($urandom), 3'($urandom), {$urandom, $urandom});
                end
            end
            else
            begin
                queue_request(3'($urandom_range(REQ_TICK, REQ_UNUSED_TOP)), 12'($urandom),
                              3'($urandom_range(KIND_NOP, KIND_UNKNOWN_TOP)),
                              {$urandom, $urandom});
            end
        end
        main_requests = stimulus.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (stimulus[k])
        begin
            if (k < main_requests / 3)
            begin
                sender_idle_pct = 30;
                receiver_stall_pct = 66;
            end
            else if (k < 2 * main_requests / 3)
            begin
                sender_idle_pct = 66;
                receiver_stall_pct = 30;
            end
            else
            begin
                sender_idle_pct = 0;
                receiver_stall_pct = 0;
            end
            while ($urandom_range(0, 99) < sender_idle_pct)
            begin
                req_ch.valid <= 1'b0;
                @(posedge clk);
            end
            req_ch.valid <= 1'b1;
            req_ch.req_type <= stimulus[k].req_type;
            req_ch.entry_address <= stimulus[k].address;
            req_ch.entry_kind <= stimulus[k].kind;
            req_ch.entry_payload <= stimulus[k].payload;
            @(posedge clk);
            while (!req_ch.ready)
            begin
                @(posedge clk);
            end
        end
        req_ch.valid <= 1'b0;

        @(posedge clk);
        while (expected_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("played %0d requests: directed table, then short random scripts with noise",
                 requests_taken);
        $display("under three handshake stall mixes; %0d reports checked, %0d of them mouse",
                 reports_checked, mouse_reports);
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- hid_report_script_player.f -----
sv/hrsp_pkg.sv
sv/hrsp_req_if.sv
sv/hrsp_rpt_if.sv
sv/hrsp_controller.sv
sv/hrsp_datapath.sv
sv/hid_report_script_player.sv
test/hid_report_script_player_test.sv
